// ----- rtl/psd_pkg.sv -----
package psd_pkg;

    localparam int CW    = 16;             // coordinate width
    localparam int PF    = 16;             // projection parameter fraction bits
    localparam int DF    = 8;              // distance fraction bits
    localparam int DISTW = 25;

    localparam int DW    = CW + 1;         // coordinate difference
    localparam int PW    = 2 * DW;         // product of two differences
    localparam int DOTW  = PW + 1;
    localparam int LW    = PW;             // squared length
    localparam int EW    = CW + PF + 3;    // signed error component
    localparam int EM    = EW - 1;         // error magnitude
    localparam int H     = (EM + 1) / 2;   // low half of a split square
    localparam int EHW   = EM - H;
    localparam int SQW   = 2 * EM + 1;
    localparam int SH    = 2 * (PF - DF);
    localparam int SW    = SQW - SH;       // root operand
    localparam int RW    = (SW + 1) / 2;

    localparam logic [1:0] REG_START    = 2'd0;
    localparam logic [1:0] REG_END      = 2'd1;
    localparam logic [1:0] REG_INTERIOR = 2'd2;

    typedef struct packed {
        logic signed [CW-1:0] seg_start_x;
        logic signed [CW-1:0] seg_start_y;
        logic signed [CW-1:0] seg_end_x;
        logic signed [CW-1:0] seg_end_y;
        logic signed [CW-1:0] point_x;
        logic signed [CW-1:0] point_y;
    } t_in;

    typedef struct packed {
        logic [DISTW-1:0] distance;
        logic [1:0]       nearest_region;
    } t_out;

    typedef struct packed {
        logic [1:0]           region;
        logic                 eq;
        logic signed [DW-1:0] a;
        logic signed [DW-1:0] b;
        logic signed [DW-1:0] c;
        logic signed [DW-1:0] d;
        logic signed [DW-1:0] pex;
        logic signed [DW-1:0] pey;
        logic [LW-1:0]        dot;
        logic [LW-1:0]        len;
    } t_mid;

endpackage

// ----- rtl/psd_fifo.sv -----
module psd_fifo #(
    parameter int W  = 8,
    parameter int AW = 2
) (
    input  logic         i_clk,
    input  logic         i_rst_n,
    input  logic         i_push,
    input  logic [W-1:0] i_data,
    output logic         o_full,
    input  logic         i_pop,
    output logic [W-1:0] o_data,
    output logic         o_empty
);

    localparam int D = 2 ** AW;

    logic [W-1:0] r_mem [D];
    logic [AW-1:0] r_wp, r_rp;
    logic [AW:0]   r_cnt;
    logic          wr, rd;

    assign o_full  = r_cnt == (AW+1)'(D);
    assign o_empty = r_cnt == '0;
    assign wr      = i_push && !o_full;
    assign rd      = i_pop && !o_empty;
    assign o_data  = r_mem[r_rp];

    always_ff @(posedge i_clk) begin
        if (wr) begin
            r_mem[r_wp] <= i_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= '0;
            r_rp  <= '0;
            r_cnt <= '0;
        end else begin
            if (wr) begin
                r_wp <= r_wp + 1'b1;
            end
            if (rd) begin
                r_rp <= r_rp + 1'b1;
            end
            if (wr && !rd) begin
                r_cnt <= r_cnt + 1'b1;
            end else if (rd && !wr) begin
                r_cnt <= r_cnt - 1'b1;
            end
        end
    end

endmodule

// ----- rtl/psd_front.sv -----
module psd_front
    import psd_pkg::*;
(
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_valid,
    input  t_in  i_item,
    output logic o_valid,
    output t_mid o_mid
);

    logic                 r_v1, r_v2, r_v3;
    logic signed [DW-1:0] r_a, r_b, r_c, r_d, r_pex, r_pey;
    logic signed [DW-1:0] r2_a, r2_b, r2_c, r2_d, r2_pex, r2_pey;
    logic signed [PW-1:0] r_ac, r_bd, r_cc, r_dd;
    t_mid                 r_mid, n_mid;
    logic signed [DOTW-1:0] dot;
    logic [LW-1:0]          len;

    function automatic logic signed [DW-1:0] diff(input logic signed [CW-1:0] p,
                                                  input logic signed [CW-1:0] q);
        return {p[CW-1], p} - {q[CW-1], q};
    endfunction

    always_ff @(posedge i_clk) begin
        r_a   <= diff(i_item.point_x, i_item.seg_start_x);
        r_b   <= diff(i_item.point_y, i_item.seg_start_y);
        r_c   <= diff(i_item.seg_end_x, i_item.seg_start_x);
        r_d   <= diff(i_item.seg_end_y, i_item.seg_start_y);
        r_pex <= diff(i_item.point_x, i_item.seg_end_x);
        r_pey <= diff(i_item.point_y, i_item.seg_end_y);

        r_ac   <= PW'(r_a) * PW'(r_c);
        r_bd   <= PW'(r_b) * PW'(r_d);
        r_cc   <= PW'(r_c) * PW'(r_c);
        r_dd   <= PW'(r_d) * PW'(r_d);
        r2_a   <= r_a;
        r2_b   <= r_b;
        r2_c   <= r_c;
        r2_d   <= r_d;
        r2_pex <= r_pex;
        r2_pey <= r_pey;

        r_mid <= n_mid;
    end

    always_comb begin
        dot = {r_ac[PW-1], r_ac} + {r_bd[PW-1], r_bd};
        len = r_cc[LW-1:0] + r_dd[LW-1:0];
        n_mid.a   = r2_a;
        n_mid.b   = r2_b;
        n_mid.c   = r2_c;
        n_mid.d   = r2_d;
        n_mid.pex = r2_pex;
        n_mid.pey = r2_pey;
        n_mid.dot = dot[LW-1:0];
        n_mid.len = len;
        n_mid.eq  = !dot[DOTW-1] && (dot[LW-1:0] == len);
        if (len == '0 || dot[DOTW-1]) begin
            n_mid.region = REG_START;
        end else if (dot[LW-1:0] > len) begin
            n_mid.region = REG_END;
        end else begin
            n_mid.region = REG_INTERIOR;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1 <= 1'b0;
            r_v2 <= 1'b0;
            r_v3 <= 1'b0;
        end else begin
            r_v1 <= i_valid;
            r_v2 <= r_v1;
            r_v3 <= r_v2;
        end
    end

    assign o_valid = r_v3;
    assign o_mid   = r_mid;

endmodule

// ----- rtl/psd_back.sv -----
module psd_back
    import psd_pkg::*;
(
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_empty,
    input  t_mid i_mid,
    output logic o_pop,
    output logic o_push,
    output t_out o_res,
    input  logic i_full
);

    localparam int NS = PF + 4 + RW;

    typedef struct packed {
        logic                 v;
        logic [1:0]           region;
        logic                 eq;
        logic signed [DW-1:0] a;
        logic signed [DW-1:0] b;
        logic signed [DW-1:0] c;
        logic signed [DW-1:0] d;
        logic signed [DW-1:0] pex;
        logic signed [DW-1:0] pey;
        logic [LW-1:0]        len;
        logic [LW:0]          rem;
        logic [PF:0]          q;
        logic signed [EW-1:0] qx;
        logic signed [EW-1:0] qy;
        logic [EM-1:0]        ex;
        logic [EM-1:0]        ey;
        logic [2*H-1:0]       xhh;
        logic [2*H-1:0]       xhl;
        logic [2*H-1:0]       xll;
        logic [2*H-1:0]       yhh;
        logic [2*H-1:0]       yhl;
        logic [2*H-1:0]       yll;
        logic [SW+1:0]        srem;
        logic [RW-1:0]        root;
    } t_bk;

    t_bk  r_st [NS];
    t_bk  n_st [NS];
    t_bk  ld;
    logic adv;

    function automatic logic [EM-1:0] mag(input logic signed [EW-1:0] e);
        logic signed [EW-1:0] m;
        m = e[EW-1] ? -e : e;
        return m[EM-1:0];
    endfunction

    function automatic logic [SQW-1:0] sq_sum(input logic [2*H-1:0] hh,
                                              input logic [2*H-1:0] hl,
                                              input logic [2*H-1:0] ll);
        return (SQW'(hh) << (2 * H)) + (SQW'(hl) << (H + 1)) + SQW'(ll);
    endfunction

    function automatic t_bk step(input int k, input t_bk s);
        t_bk                  o;
        logic [LW:0]          r2;
        logic [PF:0]          qf;
        logic signed [EW-1:0] bx, by;
        logic [EHW-1:0]       hx, hy;
        logic [H-1:0]         lx, ly;
        logic [SQW-1:0]       sum;
        logic [SW+1:0]        dl;
        int                   bit_i;
        o = s;
        if (k < PF) begin
            r2   = {s.rem[LW-1:0], 1'b0};
            o.q  = {s.q[PF-1:0], 1'b0};
            if (r2 >= {1'b0, s.len}) begin
                r2     = r2 - {1'b0, s.len};
                o.q[0] = 1'b1;
            end
            o.rem = r2;
        end else if (k == PF) begin
            qf   = s.eq ? (PF+1)'(1) << PF : s.q;
            o.qx = EW'($signed({1'b0, qf})) * EW'(s.c);
            o.qy = EW'($signed({1'b0, qf})) * EW'(s.d);
        end else if (k == PF + 1) begin
            if (s.region == REG_END) begin
                bx = EW'(s.pex) <<< PF;
                by = EW'(s.pey) <<< PF;
            end else begin
                bx = EW'(s.a) <<< PF;
                by = EW'(s.b) <<< PF;
            end
            if (s.region == REG_INTERIOR) begin
                bx = bx - s.qx;
                by = by - s.qy;
            end
            o.ex = mag(bx);
            o.ey = mag(by);
        end else if (k == PF + 2) begin
            hx    = s.ex[EM-1:H];
            lx    = s.ex[H-1:0];
            hy    = s.ey[EM-1:H];
            ly    = s.ey[H-1:0];
            o.xhh = (2*H)'(hx) * (2*H)'(hx);
            o.xhl = (2*H)'(hx) * (2*H)'(lx);
            o.xll = (2*H)'(lx) * (2*H)'(lx);
            o.yhh = (2*H)'(hy) * (2*H)'(hy);
            o.yhl = (2*H)'(hy) * (2*H)'(ly);
            o.yll = (2*H)'(ly) * (2*H)'(ly);
        end else if (k == PF + 3) begin
            sum    = sq_sum(s.xhh, s.xhl, s.xll) + sq_sum(s.yhh, s.yhl, s.yll);
            o.srem = (SW+2)'(sum >> SH);
            o.root = '0;
        end else begin
            bit_i = RW - 1 - (k - PF - 4);
            dl    = ((SW+2)'(s.root) << (bit_i + 1)) + ((SW+2)'(1) << (2 * bit_i));
            if (dl <= s.srem) begin
                o.srem        = s.srem - dl;
                o.root[bit_i] = 1'b1;
            end
        end
        return o;
    endfunction

    assign adv   = !(r_st[NS-1].v && i_full);
    assign o_pop = adv && !i_empty;

    always_comb begin
        ld        = '0;
        ld.v      = !i_empty;
        ld.region = i_mid.region;
        ld.eq     = i_mid.eq;
        ld.a      = i_mid.a;
        ld.b      = i_mid.b;
        ld.c      = i_mid.c;
        ld.d      = i_mid.d;
        ld.pex    = i_mid.pex;
        ld.pey    = i_mid.pey;
        ld.len    = i_mid.len;
        ld.rem    = {1'b0, i_mid.dot};
        n_st[0]   = step(0, ld);
        for (int k = 1; k < NS; k++) begin
            n_st[k] = step(k, r_st[k-1]);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int k = 0; k < NS; k++) begin
                r_st[k].v <= 1'b0;
            end
        end else if (adv) begin
            for (int k = 0; k < NS; k++) begin
                r_st[k] <= n_st[k];
            end
        end
    end

    assign o_push               = r_st[NS-1].v;
    assign o_res.distance       = r_st[NS-1].root[DISTW-1:0];
    assign o_res.nearest_region = r_st[NS-1].region;

endmodule

// ----- rtl/point_segment_distance_top.sv -----
// Point to segment distance, 2-D, fixed point.
// Input queue port: drive i_item and raise push; the beat is taken on a
// clock edge where push is high and full is low. Each item is a segment
// (start, end) and a query point, signed coordinates.
// Result queue port: while empty is low, o_result holds the oldest
// result (distance with 8 fraction bits, floor of the root, and the
// nearest region); raising pop takes that beat.
// Throughput: one item per cycle sustained while results are popped.
// Register stages: 3 front stages, the queue write, 47 back stages
// (16 divide steps, 4 error/square stages, 27 root steps) and the output
// queue write, 52 register stages with the first at the accepting edge.
// The front pipeline runs freely and lands in an 8-entry queue; full is
// raised when 8 items sit in the front or in that queue. If the result
// side is not popped, the back pipeline holds, the queue fills and full
// rises; nothing is dropped.
// Reset (synchronous, active low) empties every stage and both queues.
module point_segment_distance_top
    import psd_pkg::*;
(
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic push,
    input  t_in  i_item,
    output logic full,
    input  logic pop,
    output t_out o_result,
    output logic empty
);

    localparam int QAW = 3;
    localparam int QD  = 2 ** QAW;

    logic         acc;
    logic         f_valid;
    t_mid         f_mid;
    t_mid         q_mid;
    logic         q_empty, q_full, q_pop;
    logic         b_push, o_full_q;
    t_out         b_res;
    logic [QAW:0] r_cnt;

    assign full = r_cnt == (QAW+1)'(QD);
    assign acc  = push && !full;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cnt <= '0;
        end else if (acc && !q_pop) begin
            r_cnt <= r_cnt + 1'b1;
        end else if (q_pop && !acc) begin
            r_cnt <= r_cnt - 1'b1;
        end
    end

    psd_front u_front (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (acc),
        .i_item  (i_item),
        .o_valid (f_valid),
        .o_mid   (f_mid)
    );

    psd_fifo #(.W($bits(t_mid)), .AW(QAW)) u_mid_q (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (f_valid),
        .i_data  (f_mid),
        .o_full  (q_full),
        .i_pop   (q_pop),
        .o_data  (q_mid),
        .o_empty (q_empty)
    );

    psd_back u_back (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_empty (q_empty || (q_full && 1'b0)),
        .i_mid   (q_mid),
        .o_pop   (q_pop),
        .o_push  (b_push),
        .o_res   (b_res),
        .i_full  (o_full_q)
    );

    psd_fifo #(.W($bits(t_out)), .AW(1)) u_out_q (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (b_push),
        .i_data  (b_res),
        .o_full  (o_full_q),
        .i_pop   (pop),
        .o_data  (o_result),
        .o_empty (empty)
    );

endmodule
